/* src/hpt_pkg.sv */
// Shared constants and payload types for the homogeneous point transform.
package hpt_pkg;

  // Fixed-point format of matrix entries, points and results
  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int CFG_W     = 2 * COORD_W;
  localparam int N_REGS    = 8;
  localparam int CFG_IDX_W = 4;
  localparam int REG_SEL_W = $clog2(N_REGS);

  // Wide datapath widths
  localparam int PROD_W    = 2 * COORD_W;
  localparam int ACC_W     = PROD_W + 2;
  localparam int DD_W      = ACC_W + COORD_W;
  localparam int REM_W     = DD_W + 1;
  localparam int Q_W       = COORD_W + 1;
  localparam int DIV_STEPS = Q_W;

  localparam logic [COORD_W-1:0] FX_ONE  = COORD_W'(1) << FRAC_BITS;
  localparam logic [COORD_W-1:0] POS_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] NEG_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  // Register reset values: identity matrix
  localparam logic [CFG_W-1:0] REG_RESET [N_REGS] = '{
    {FX_ONE, {COORD_W{1'b0}}}, {CFG_W{1'b0}},
    {{COORD_W{1'b0}}, FX_ONE}, {CFG_W{1'b0}},
    {CFG_W{1'b0}}, {FX_ONE, {COORD_W{1'b0}}},
    {CFG_W{1'b0}}, {{COORD_W{1'b0}}, FX_ONE}
  };

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
  } pt_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic                      w_was_zero;
    logic                      saturated;
  } pt_out_t;

  // Per-item state carried through the divider stages
  typedef struct packed {
    logic [2:0][REM_W-1:0]   rem;
    logic [2:0][Q_W-1:0]     quo;
    logic [2:0]              neg;
    logic [2:0]              ovf;
    logic [DD_W-1:0]         dd;
    logic                    wz;
    logic [2:0][COORD_W-1:0] zres;
    logic [2:0]              zsat;
  } div_t;

  typedef logic [N_REGS-1:0][CFG_W-1:0] mat_t;

endpackage

/* src/hpt_if.sv */
// Valid/ready channel interfaces for points in and transformed points out.
interface hpt_in_if;
  import hpt_pkg::*;
  logic   valid;
  logic   ready;
  pt_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hpt_out_if;
  import hpt_pkg::*;
  logic    valid;
  logic    ready;
  pt_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* src/hpt_front.sv */
// Front stages: multiply, row sums, magnitudes and divide overflow check.
module hpt_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           ce,
  input  logic           in_valid,
  input  hpt_pkg::pt_in_t in_data,
  input  hpt_pkg::mat_t  mat,
  output logic           out_valid,
  output hpt_pkg::div_t  out_data
);
  import hpt_pkg::*;

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  logic                    v1_r, v2_r, v3_r, v4_r;
  prod_t [3:0][2:0]        prod_r, prod_nxt;
  acc_t  [3:0]             trans_r, trans_nxt;
  acc_t  [3:0]             acc_r, acc_nxt;
  div_t                    s3_r, s3_nxt;
  div_t                    s4_r, s4_nxt;

  // Stage 1: twelve products and the scaled translations
  always_comb begin
    logic signed [COORD_W-1:0] pc [3];
    logic signed [COORD_W-1:0] e;
    pc[0] = in_data.point_x;
    pc[1] = in_data.point_y;
    pc[2] = in_data.point_z;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 3; c++) begin
        e = (c % 2 == 1) ? $signed(mat[2*r + c/2][COORD_W-1:0])
                         : $signed(mat[2*r + c/2][CFG_W-1:COORD_W]);
        prod_nxt[r][c] = PROD_W'(pc[c]) * PROD_W'(e);
      end
      e = $signed(mat[2*r + 1][COORD_W-1:0]);
      trans_nxt[r] = ACC_W'(e) <<< FRAC_BITS;
    end
  end

  // Stage 2: row sums
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      acc_nxt[r] = ACC_W'(prod_r[r][0]) + ACC_W'(prod_r[r][1])
                 + ACC_W'(prod_r[r][2]) + trans_r[r];
    end
  end

  // Stage 3: signs, magnitudes, divisor and the undivided results
  always_comb begin
    acc_t             mag;
    acc_t             wmag;
    acc_t             sh;
    logic             nw;
    s3_nxt = '0;
    nw     = acc_r[3][ACC_W-1];
    wmag   = nw ? -acc_r[3] : acc_r[3];
    s3_nxt.wz = (acc_r[3] == '0);
    s3_nxt.dd = {wmag, {COORD_W{1'b0}}};
    for (int k = 0; k < 3; k++) begin
      mag = acc_r[k][ACC_W-1] ? -acc_r[k] : acc_r[k];
      s3_nxt.neg[k] = acc_r[k][ACC_W-1] ^ nw;
      s3_nxt.rem[k] = REM_W'({mag, {FRAC_BITS{1'b0}}});
      sh = acc_r[k] >>> FRAC_BITS;
      if (&sh[ACC_W-1:COORD_W-1] || ~|sh[ACC_W-1:COORD_W-1]) begin
        s3_nxt.zres[k] = sh[COORD_W-1:0];
        s3_nxt.zsat[k] = 1'b0;
      end else begin
        s3_nxt.zres[k] = sh[ACC_W-1] ? NEG_MIN : POS_MAX;
        s3_nxt.zsat[k] = 1'b1;
      end
    end
  end

  // Stage 4: flag quotients of 2^33 or more
  always_comb begin
    s4_nxt = s3_r;
    for (int k = 0; k < 3; k++) begin
      s4_nxt.ovf[k] = s3_r.rem[k] >= {s3_r.dd, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (ce) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Advance payload with the valid bits
  always_ff @(posedge clk) begin
    if (ce) begin
      prod_r  <= prod_nxt;
      trans_r <= trans_nxt;
      acc_r   <= acc_nxt;
      s3_r    <= s3_nxt;
      s4_r    <= s4_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_data  = s4_r;

endmodule

/* src/hpt_div_step.sv */
// One restoring-divide stage: one quotient bit for each of the three coordinates.
module hpt_div_step (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          ce,
  input  logic          in_valid,
  input  hpt_pkg::div_t in_data,
  output logic          out_valid,
  output hpt_pkg::div_t out_data
);
  import hpt_pkg::*;

  logic valid_r;
  div_t data_r, data_nxt;

  // Compare against the aligned divisor, subtract, shift the remainder up
  always_comb begin
    logic             ge;
    logic [REM_W-1:0] r1;
    data_nxt = in_data;
    for (int k = 0; k < 3; k++) begin
      ge = in_data.rem[k] >= REM_W'(in_data.dd);
      r1 = ge ? in_data.rem[k] - REM_W'(in_data.dd) : in_data.rem[k];
      data_nxt.rem[k] = r1 << 1;
      data_nxt.quo[k] = {in_data.quo[k][Q_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ce) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

/* src/homogeneous_point_transform_core.sv */
// Top level: matrix registers, front stages, divider pipeline and output saturation.
//
//  channel  | dir | handshake           | payload
//  ---------+-----+---------------------+-------------------------------------------
//  in_ch    | in  | valid/ready         | point_x, point_y, point_z (Q16.16)
//  out_ch   | out | valid/ready         | out_x, out_y, out_z, w_was_zero, saturated
//  cfg_*    | in  | cfg_we, no stall    | cfg_index, cfg_wdata (64-bit matrix row pair)
//
// One point enters per cycle unless stalled; stages: 4 front stages (multiply,
// sum, magnitude, overflow check), 33 divider stages at one quotient bit each,
// and the saturating output register. The whole pipeline advances together
// whenever the output register is empty or being taken, so in_ch.ready follows
// out_ch.ready. Reset (synchronous) loads the identity matrix and empties the pipe.
module homogeneous_point_transform_core (
  input  logic                            clk,
  input  logic                            rst_n,
  hpt_in_if.sink                          in_ch,
  hpt_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [hpt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hpt_pkg::CFG_W-1:0]       cfg_wdata
);
  import hpt_pkg::*;

  mat_t    mat_r;
  logic    ce;
  logic    out_valid_r;
  pt_out_t out_r, out_nxt;
  logic    step_v [DIV_STEPS+1];
  div_t    step_d [DIV_STEPS+1];

  // Advance when the output register is free or being drained
  assign ce          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = ce;

  // Matrix registers; indexes past the last register are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N_REGS; i++) begin
        mat_r[i] <= REG_RESET[i];
      end
    end else if (cfg_we && cfg_index < CFG_IDX_W'(N_REGS)) begin
      mat_r[cfg_index[REG_SEL_W-1:0]] <= cfg_wdata;
    end
  end

  hpt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (in_ch.valid),
    .in_data   (in_ch.data),
    .mat       (mat_r),
    .out_valid (step_v[0]),
    .out_data  (step_d[0])
  );

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
    hpt_div_step u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .ce        (ce),
      .in_valid  (step_v[s]),
      .in_data   (step_d[s]),
      .out_valid (step_v[s+1]),
      .out_data  (step_d[s+1])
    );
  end

  // Sign, saturate and pick the undivided path when w is zero
  always_comb begin
    div_t                     d;
    logic [2:0][COORD_W-1:0]  res;
    logic [2:0]               sat;
    logic [Q_W-1:0]           q;
    d = step_d[DIV_STEPS];
    for (int k = 0; k < 3; k++) begin
      q = d.quo[k];
      if (d.wz) begin
        res[k] = d.zres[k];
        sat[k] = d.zsat[k];
      end else if (d.neg[k]) begin
        sat[k] = d.ovf[k] || q[Q_W-1] || (q[COORD_W-1] && |q[COORD_W-2:0]);
        res[k] = sat[k] ? NEG_MIN : -q[COORD_W-1:0];
      end else begin
        sat[k] = d.ovf[k] || q[Q_W-1] || q[COORD_W-1];
        res[k] = sat[k] ? POS_MAX : q[COORD_W-1:0];
      end
    end
    out_nxt.out_x      = res[0];
    out_nxt.out_y      = res[1];
    out_nxt.out_z      = res[2];
    out_nxt.w_was_zero = d.wz;
    out_nxt.saturated  = |sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ce) begin
      out_valid_r <= step_v[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

endmodule

/* src/hpt_checker.sv */
// Port-level checks for the point transform core, bound to the top level.
module hpt_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input hpt_pkg::pt_out_t out_data
);
  import hpt_pkg::*;

  // Hold a stalled item
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output item changed or dropped");

  // Empty pipe right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("output valid right after reset");

  // Input side stalls only behind a held output
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

  // A clamped item shows a rail value
  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |->
      out_data.out_x == POS_MAX || out_data.out_x == NEG_MIN ||
      out_data.out_y == POS_MAX || out_data.out_y == NEG_MIN ||
      out_data.out_z == POS_MAX || out_data.out_z == NEG_MIN)
    else $error("saturated flag without a clamped coordinate");

endmodule

bind homogeneous_point_transform_core hpt_checker u_hpt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

/* tb/tb.sv */
// Self-checking testbench for the homogeneous point transform core.
`timescale 1ns / 1ps

module tb;
  import hpt_pkg::*;

  localparam int HALF_PERIOD = 6;
  localparam int MAX_GAP     = 16;
  localparam int LATENCY     = 38;
  localparam int STALL_LIMIT = 4000;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 55;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] IDX_ROW0_C01 = 4'd0;
  localparam logic [CFG_IDX_W-1:0] IDX_ROW0_C23 = 4'd1;
  localparam logic [CFG_IDX_W-1:0] IDX_ROW1_C01 = 4'd2;
  localparam logic [CFG_IDX_W-1:0] IDX_ROW1_C23 = 4'd3;
  localparam logic [CFG_IDX_W-1:0] IDX_ROW2_C01 = 4'd4;
  localparam logic [CFG_IDX_W-1:0] IDX_ROW2_C23 = 4'd5;
  localparam logic [CFG_IDX_W-1:0] IDX_ROW3_C01 = 4'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_ROW3_C23 = 4'd7;
  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED   = 4'd8;
  localparam logic [CFG_IDX_W-1:0] IDX_TOP      = 4'hF;

  localparam logic [COORD_W-1:0] FX_TWO     = 32'h0002_0000;
  localparam logic [COORD_W-1:0] FX_NEG_ONE = 32'hFFFF_0000;
  localparam logic [COORD_W-1:0] FX_ZERO    = 32'h0;

  typedef enum logic [1:0] {MAT_KEEP, MAT_W_ZERO, MAT_NEG_W, MAT_SCALE2} mat_sel_t;

  typedef struct {
    mat_sel_t mat;
    pt_in_t   pt;
    bit       typed;
    pt_out_t  res;
  } vec_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  hpt_in_if  in_ch ();
  hpt_out_if out_ch ();

  homogeneous_point_transform_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  logic [CFG_W-1:0] matrix_regs [N_REGS];
  pt_out_t          pending_results [$];
  int               fail_count = 0;
  int               idle_cycles = 0;
  bit               quiet = 1'b0;
  bit               stim_done = 1'b0;
  vec_row_t         vectors [$];

  always #HALF_PERIOD clk = ~clk;

  // Return one matrix entry sign-extended to the wide datapath
  function automatic logic signed [127:0] coef(int row, int col);
    logic [CFG_W-1:0] r;
    logic signed [COORD_W-1:0] e;
    r = matrix_regs[row * 2 + col / 2];
    e = (col % 2 == 1) ? r[COORD_W-1:0] : r[CFG_W-1:COORD_W];
    return e;
  endfunction

  // Clamp a sign and magnitude to a 32-bit word
  function automatic logic [COORD_W-1:0] clamp_coord(bit neg, logic [127:0] mag,
                                                     ref bit sat);
    if (neg) begin
      if (mag > 128'h8000_0000) begin
        sat = 1'b1;
        return NEG_MIN;
      end
      return COORD_W'(-mag);
    end
    if (mag > 128'h7FFF_FFFF) begin
      sat = 1'b1;
      return POS_MAX;
    end
    return mag[COORD_W-1:0];
  endfunction

  // Transform one point through the current matrix, with divide by w
  function automatic pt_out_t transform_point(pt_in_t p);
    logic signed [127:0] sums [4];
    logic signed [127:0] xs, ys, zs, v;
    logic [127:0] num, den, quo;
    logic [COORD_W-1:0] coords [3];
    bit sat, wz, nn, nd;
    pt_out_t r;
    xs = p.point_x;
    ys = p.point_y;
    zs = p.point_z;
    sat = 1'b0;
    for (int k = 0; k < 4; k++)
      sums[k] = xs * coef(k, 0) + ys * coef(k, 1) + zs * coef(k, 2)
                + (coef(k, 3) <<< FRAC_BITS);
    wz = (sums[3] == 0);
    for (int k = 0; k < 3; k++) begin
      if (wz) begin
        v = sums[k] >>> FRAC_BITS;
        nn = v[127];
        coords[k] = clamp_coord(nn, nn ? -v : v, sat);
      end else begin
        nn = sums[k][127];
        nd = sums[3][127];
        num = nn ? -sums[k] : sums[k];
        den = nd ? -sums[3] : sums[3];
        quo = (num << FRAC_BITS) / den;
        coords[k] = clamp_coord(nn != nd, quo, sat);
      end
    end
    r.out_x = coords[0];
    r.out_y = coords[1];
    r.out_z = coords[2];
    r.w_was_zero = wz;
    r.saturated = sat;
    return r;
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? POS_MAX : NEG_MIN;
      2: return FX_ZERO;
      default: return COORD_W'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] rand_entry();
    case ($urandom_range(0, 7))
      0: return $urandom();
      1: return FX_ZERO;
      2: return $urandom_range(0, 1) ? FX_ONE : FX_NEG_ONE;
      default: return COORD_W'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
    endcase
  endfunction

  // Write one register at the next edge; keep the enable high for bursts
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx < N_REGS) matrix_regs[idx] = val;
  endtask

  task automatic load_matrix(logic [CFG_W-1:0] m [N_REGS]);
    for (int i = 0; i < N_REGS; i++) write_reg(CFG_IDX_W'(i), m[i]);
    cfg_we <= 1'b0;
  endtask

  // Hold off until every expected result has come back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_point(pt_in_t p);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= p;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(transform_point(p));
  endtask

  function automatic pt_in_t mk_pt(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                   logic [COORD_W-1:0] z);
    pt_in_t p;
    p.point_x = x;
    p.point_y = y;
    p.point_z = z;
    return p;
  endfunction

  function automatic pt_out_t mk_res(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                     logic [COORD_W-1:0] z, bit wz, bit sat);
    pt_out_t r;
    r.out_x = x;
    r.out_y = y;
    r.out_z = z;
    r.w_was_zero = wz;
    r.saturated = sat;
    return r;
  endfunction

  function automatic void add_vec(mat_sel_t m, pt_in_t p, bit typed, pt_out_t r);
    vec_row_t v;
    v.mat = m;
    v.pt = p;
    v.typed = typed;
    v.res = r;
    vectors.push_back(v);
  endfunction

  // Identity with a chosen last row and diagonal scale
  task automatic apply_matrix(mat_sel_t sel);
    logic [CFG_W-1:0] m [N_REGS];
    logic [COORD_W-1:0] d;
    d = (sel == MAT_SCALE2) ? FX_TWO : FX_ONE;
    m[IDX_ROW0_C01] = {d, FX_ZERO};
    m[IDX_ROW0_C23] = '0;
    m[IDX_ROW1_C01] = {FX_ZERO, d};
    m[IDX_ROW1_C23] = '0;
    m[IDX_ROW2_C01] = '0;
    m[IDX_ROW2_C23] = {d, FX_ZERO};
    m[IDX_ROW3_C01] = '0;
    case (sel)
      MAT_W_ZERO: m[IDX_ROW3_C23] = '0;
      MAT_NEG_W:  m[IDX_ROW3_C23] = {FX_ZERO, FX_NEG_ONE};
      default:    m[IDX_ROW3_C23] = {FX_ZERO, FX_ONE};
    endcase
    load_matrix(m);
  endtask

  task automatic random_matrix();
    logic [CFG_W-1:0] m [N_REGS];
    case ($urandom_range(0, 9))
      0: for (int i = 0; i < N_REGS; i++) m[i] = '1;
      1: for (int i = 0; i < N_REGS; i++) m[i] = {$urandom(), $urandom()};
      default: begin
        for (int i = 0; i < N_REGS; i++) m[i] = {rand_entry(), rand_entry()};
        // pick the shape of the w row
        case ($urandom_range(0, 3))
          0: begin
            m[IDX_ROW3_C01] = '0;
            m[IDX_ROW3_C23] = {FX_ZERO, FX_ONE};
          end
          1: begin
            m[IDX_ROW3_C01] = '0;
            m[IDX_ROW3_C23] = '0;
          end
          2: begin
            m[IDX_ROW3_C01] = '0;
            m[IDX_ROW3_C23] = {FX_NEG_ONE, FX_ZERO};
          end
          default: ;
        endcase
      end
    endcase
    load_matrix(m);
  endtask

  task automatic check_field(string name, logic [COORD_W-1:0] exp_v,
                             logic [COORD_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Result side: random stalls, compare each taken item with the oldest expectation
  initial begin
    int gap;
    pt_out_t exp_r, got;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      got = out_ch.data;
      if (pending_results.size() == 0) begin
        $error("unexpected result item: %h", got);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("out_x", exp_r.out_x, got.out_x);
        check_field("out_y", exp_r.out_y, got.out_y);
        check_field("out_z", exp_r.out_z, got.out_z);
        check_field("w_was_zero", exp_r.w_was_zero, got.w_was_zero);
        check_field("saturated", exp_r.saturated, got.saturated);
      end
    end
  end

  // Watchdog: end the run when neither channel moves for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT && !stim_done) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Stimulus
  initial begin
    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_index   <= '0;
    cfg_wdata   <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    for (int i = 0; i < N_REGS; i++) matrix_regs[i] = REG_RESET[i];
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: identity after reset, w zero, negative w, scale to saturation
    add_vec(MAT_KEEP, mk_pt(32'h0001_0000, 32'h0002_0000, 32'h0003_0000), 1,
            mk_res(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 0, 0));
    add_vec(MAT_KEEP, mk_pt(POS_MAX, NEG_MIN, FX_ZERO), 1,
            mk_res(POS_MAX, NEG_MIN, FX_ZERO, 0, 0));
    add_vec(MAT_KEEP, mk_pt(32'hFFFF_FFFF, 32'h0000_0001, NEG_MIN), 1,
            mk_res(32'hFFFF_FFFF, 32'h0000_0001, NEG_MIN, 0, 0));
    add_vec(MAT_KEEP, mk_pt(32'h1234_5678, 32'h8765_4321, 32'hAAAA_5555), 0, '0);
    add_vec(MAT_W_ZERO, mk_pt(32'h0001_0000, 32'hFFFF_0000, FX_ZERO), 1,
            mk_res(32'h0001_0000, 32'hFFFF_0000, FX_ZERO, 1, 0));
    add_vec(MAT_W_ZERO, mk_pt(POS_MAX, NEG_MIN, 32'hFFFF_FFFF), 1,
            mk_res(POS_MAX, NEG_MIN, 32'hFFFF_FFFF, 1, 0));
    add_vec(MAT_NEG_W, mk_pt(FX_ZERO, FX_ZERO, FX_ZERO), 1,
            mk_res(FX_ZERO, FX_ZERO, FX_ZERO, 0, 0));
    add_vec(MAT_NEG_W, mk_pt(32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001), 1,
            mk_res(32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_FFFF, 0, 0));
    add_vec(MAT_NEG_W, mk_pt(NEG_MIN, POS_MAX, FX_ZERO), 1,
            mk_res(POS_MAX, 32'h8000_0001, FX_ZERO, 0, 1));
    add_vec(MAT_SCALE2, mk_pt(POS_MAX, NEG_MIN, FX_ONE), 1,
            mk_res(POS_MAX, NEG_MIN, FX_TWO, 0, 1));
    add_vec(MAT_SCALE2, mk_pt(32'h0000_0003, 32'hC000_0000, 32'h3FFF_FFFF), 1,
            mk_res(32'h0000_0006, NEG_MIN, 32'h7FFF_FFFE, 0, 0));
    add_vec(MAT_SCALE2, mk_pt(32'h4000_0000, FX_ZERO, FX_ZERO), 1,
            mk_res(POS_MAX, FX_ZERO, FX_ZERO, 0, 1));

    foreach (vectors[i]) begin
      if (vectors[i].mat != MAT_KEEP &&
          (i == 0 || vectors[i].mat != vectors[i-1].mat)) begin
        wait_drained();
        apply_matrix(vectors[i].mat);
      end
      send_point(vectors[i].pt);
      if (vectors[i].typed && pending_results[$] != vectors[i].res) begin
        $error("typed expectation differs from prediction for row %0d", i);
        fail_count++;
        pending_results[$] = vectors[i].res;
      end
    end

    // Out-of-range index must leave the matrix alone
    wait_drained();
    write_reg(IDX_UNUSED, '1);
    write_reg(IDX_TOP, '0);
    cfg_we <= 1'b0;
    send_point(mk_pt(32'h0005_0000, 32'hFFFB_0000, 32'h0000_8000));

    // Random phases, each under a fresh matrix
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_drained();
      random_matrix();
      quiet = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_point(mk_pt(rand_coord(), rand_coord(), rand_coord()));
    end

    wait_drained();
    quiet = 1'b0;
    repeat (LATENCY + 10) @(posedge clk);
    stim_done = 1'b1;
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
